// File: rtl/vt100_escape_filter_defines.svh
// Assertion macros shared by the checker files of the escape filter.
// Expects a clock named clk and a synchronous reset named rst in scope.
`ifndef VT100_ESCAPE_FILTER_DEFINES_SVH
`define VT100_ESCAPE_FILTER_DEFINES_SVH

// Check on the next cycle, ignored while reset is high.
`define VTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Check on the next cycle, also across reset.
`define VTF_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/vtf_pkg.sv
// Shared types and constants of the escape filter.
// No dependencies; imported by the decode, window, queue and top-level modules.
package vtf_pkg;

  localparam int LOOKAHEAD_BYTES = 14;
  localparam int FILL_W          = $clog2(LOOKAHEAD_BYTES + 1);
  localparam int SKIP_W          = 4;

  // Scan ranges for the closing 'm' of a CSI sequence
  localparam int EXT_SCAN_FROM = 7;
  localparam int EXT_SCAN_END  = 14;
  localparam int GEN_SCAN_FROM = 2;
  localparam int GEN_SCAN_END  = 10;

  // Character codes
  localparam logic [7:0] ESC_CODE    = 8'd27;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_M        = 8'h6D;
  localparam logic [7:0] CH_K        = 8'h4B;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_0        = 8'h30;
  localparam logic [7:0] CH_1        = 8'h31;
  localparam logic [7:0] CH_2        = 8'h32;
  localparam logic [7:0] CH_3        = 8'h33;
  localparam logic [7:0] CH_4        = 8'h34;
  localparam logic [7:0] CH_5        = 8'h35;
  localparam logic [7:0] CH_8        = 8'h38;

  // Translated clear-line codes
  localparam logic [7:0] CODE_K = 8'd75;
  localparam logic [7:0] CODE_O = 8'd111;
  localparam logic [7:0] CODE_L = 8'd108;

  // Number of words one head action emits
  localparam logic [1:0] EMIT_NONE = 2'd0;
  localparam logic [1:0] EMIT_ONE  = 2'd1;
  localparam logic [1:0] EMIT_TWO  = 2'd2;

  typedef logic [LOOKAHEAD_BYTES-1:0][7:0] window_t;

  // Decoded action on the window head (skip not yet applied)
  typedef struct packed {
    logic [1:0]        emit_cnt;
    logic [7:0]        byte_a;
    logic [7:0]        byte_b;
    logic [SKIP_W-1:0] skip_add;
  } head_act_t;

  // One word toward the output queue
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_last;
  } result_t;

endpackage

// File: rtl/vtf_in_if.sv
// Input channel of the escape filter: raw byte plus end-of-buffer mark.
// No dependencies.
interface vtf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       buffer_end;

  modport source(output valid, output in_byte, output buffer_end, input ready);
  modport sink(input valid, input in_byte, input buffer_end, output ready);
endinterface

// File: rtl/vtf_out_if.sv
// Output channel of the escape filter: filtered byte, byte flag, last mark.
// No dependencies.
interface vtf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       out_last;

  modport source(output valid, output out_byte, output byte_valid, output out_last,
                 input ready);
  modport sink(input valid, input out_byte, input byte_valid, input out_last,
               output ready);
endinterface

// File: rtl/vtf_head_decode.sv
// Combinational rule decode of the byte at the head of the lookahead window.
// Depends on vtf_pkg.
module vtf_head_decode import vtf_pkg::*; (
  input  window_t           win,
  input  logic [FILL_W-1:0] fill,
  output head_act_t         act
);

  window_t           p;
  logic              is_csi;
  logic              ext_pfx;
  logic              k_ok;
  logic [7:0]        k_code;
  logic [SKIP_W-1:0] ext_skip;
  logic [SKIP_W-1:0] gen_skip;

  // Mask positions past the fill level to zero
  always_comb begin
    for (int i = 0; i < LOOKAHEAD_BYTES; i++) begin
      p[i] = (FILL_W'(i) < fill) ? win[i] : 8'd0;
    end
  end

  assign is_csi  = (p[0] == ESC_CODE) && (p[1] == CH_LBRACKET);
  assign ext_pfx = ((p[2] == CH_3) || (p[2] == CH_4)) && (p[3] == CH_8) &&
                   (p[4] == CH_SEMI) && (p[5] == CH_5) && (p[6] == CH_SEMI);

  // Find the first 'm' of each scan range; none found drops only ESC '['
  always_comb begin
    ext_skip = SKIP_W'(1);
    for (int k = EXT_SCAN_END - 1; k >= EXT_SCAN_FROM; k--) begin
      if (p[k] == CH_M) ext_skip = SKIP_W'(k);
    end
  end

  always_comb begin
    gen_skip = SKIP_W'(1);
    for (int k = GEN_SCAN_END - 1; k >= GEN_SCAN_FROM; k--) begin
      if (p[k] == CH_M) gen_skip = SKIP_W'(k);
    end
  end

  // Map the clear-line digit
  always_comb begin
    k_ok   = 1'b1;
    k_code = CODE_K;
    case (p[2])
      CH_0:    k_code = CODE_K;
      CH_1:    k_code = CODE_O;
      CH_2:    k_code = CODE_L;
      default: k_ok = 1'b0;
    endcase
  end

  // Apply the rules in priority order
  always_comb begin
    act.emit_cnt = EMIT_ONE;
    act.byte_a   = p[0];
    act.byte_b   = CODE_K;
    act.skip_add = '0;
    if (is_csi) begin
      act.emit_cnt = EMIT_NONE;
      act.byte_a   = ESC_CODE;
      if (p[3] == CH_M) begin
        act.skip_add = SKIP_W'(3);
      end else if (p[4] == CH_M) begin
        act.skip_add = SKIP_W'(4);
      end else if (p[5] == CH_M) begin
        act.skip_add = SKIP_W'(5);
      end else if (p[2] == CH_K) begin
        act.emit_cnt = EMIT_TWO;
        act.skip_add = SKIP_W'(2);
      end else if (p[3] == CH_K) begin
        act.emit_cnt = k_ok ? EMIT_TWO : EMIT_ONE;
        act.byte_b   = k_code;
        act.skip_add = SKIP_W'(3);
      end else if (ext_pfx) begin
        act.skip_add = ext_skip;
      end else begin
        act.skip_add = gen_skip;
      end
    end
  end

endmodule

// File: rtl/vtf_window.sv
// Lookahead window, skip counter and flush sequencing of the escape filter.
// Depends on vtf_pkg and vtf_in_if; takes its head action from vtf_head_decode.
module vtf_window import vtf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  vtf_in_if.sink            raw,
  input  head_act_t         act,
  input  logic              room,
  output window_t           win,
  output logic [FILL_W-1:0] fill,
  output logic              push,
  output result_t           push_data
);

  localparam logic [FILL_W-1:0] FULL = FILL_W'(LOOKAHEAD_BYTES);

  logic [SKIP_W-1:0] skip, skip_next;
  logic              flushing, flushing_next;
  logic              pend, pend_next;
  logic [7:0]        pend_byte, pend_byte_next;
  logic              pend_flush, pend_flush_next;
  logic              hold_valid, hold_valid_next;
  logic [7:0]        hold_byte, hold_byte_next;
  window_t           win_next;
  logic [FILL_W-1:0] fill_next;

  window_t           shifted;
  logic [FILL_W-1:0] fill_a;
  logic              do_pend, do_act, do_end, take;
  logic              gen_valid, gen_flush;
  logic [7:0]        gen_byte;

  // Decide what moves this cycle
  assign do_pend   = room && pend;
  assign do_act    = room && !pend &&
                     ((flushing && (fill != '0)) || (!flushing && (fill == FULL)));
  assign do_end    = room && !pend && flushing && (fill == '0);
  assign raw.ready = !flushing && !pend && ((fill != FULL) || do_act);
  assign take      = raw.valid && raw.ready;

  // Head action, byte append, result routing
  always_comb begin
    skip_next       = skip;
    flushing_next   = flushing;
    pend_next       = pend;
    pend_byte_next  = pend_byte;
    pend_flush_next = pend_flush;
    hold_valid_next = hold_valid;
    hold_byte_next  = hold_byte;
    shifted         = win;
    fill_a          = fill;
    gen_valid       = 1'b0;
    gen_byte        = act.byte_a;
    gen_flush       = flushing;
    push            = 1'b0;
    push_data       = '0;

    // Emit the second word of a clear-line translation
    if (do_pend) begin
      pend_next = 1'b0;
      gen_valid = 1'b1;
      gen_byte  = pend_byte;
      gen_flush = pend_flush;
    end

    // Pop the head, either skipping it or acting on it
    if (do_act) begin
      for (int i = 0; i < LOOKAHEAD_BYTES - 1; i++) begin
        shifted[i] = win[i+1];
      end
      fill_a = fill - FILL_W'(1);
      if (skip != '0) begin
        skip_next = skip - SKIP_W'(1);
      end else begin
        skip_next       = act.skip_add;
        gen_valid       = (act.emit_cnt != EMIT_NONE);
        pend_next       = (act.emit_cnt == EMIT_TWO);
        pend_byte_next  = act.byte_b;
        pend_flush_next = flushing;
      end
    end

    // Append the accepted byte behind the current fill
    win_next  = shifted;
    fill_next = fill_a;
    if (take) begin
      for (int i = 0; i < LOOKAHEAD_BYTES; i++) begin
        if (fill_a == FILL_W'(i)) win_next[i] = raw.in_byte;
      end
      fill_next = fill_a + FILL_W'(1);
      if (raw.buffer_end) flushing_next = 1'b1;
    end

    // Stream words go straight out; flush words wait in the hold register to learn the last
    if (gen_valid) begin
      if (!gen_flush) begin
        push      = 1'b1;
        push_data = '{out_byte: gen_byte, byte_valid: 1'b1, out_last: 1'b0};
      end else begin
        push            = hold_valid;
        push_data       = '{out_byte: hold_byte, byte_valid: 1'b1, out_last: 1'b0};
        hold_valid_next = 1'b1;
        hold_byte_next  = gen_byte;
      end
    end

    // Close the flush with the held word or an empty marker
    if (do_end) begin
      push            = 1'b1;
      push_data       = hold_valid ?
                        result_t'{out_byte: hold_byte, byte_valid: 1'b1, out_last: 1'b1} :
                        result_t'{out_byte: 8'd0, byte_valid: 1'b0, out_last: 1'b1};
      hold_valid_next = 1'b0;
      flushing_next   = 1'b0;
      skip_next       = '0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      skip       <= '0;
      flushing   <= 1'b0;
      pend       <= 1'b0;
      pend_flush <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      fill       <= fill_next;
      skip       <= skip_next;
      flushing   <= flushing_next;
      pend       <= pend_next;
      pend_flush <= pend_flush_next;
      hold_valid <= hold_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    win       <= win_next;
    pend_byte <= pend_byte_next;
    hold_byte <= hold_byte_next;
  end

endmodule

// File: rtl/vtf_out_queue.sv
// Two-word output queue that decouples the filter from output stalls.
// Depends on vtf_pkg and vtf_out_if.
module vtf_out_queue import vtf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  result_t  push_data,
  output logic     room,
  vtf_out_if.source filt
);

  result_t    mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] cnt, cnt_next;
  logic       pop;
  result_t    head;

  assign pop  = filt.valid && filt.ready;
  assign room = (cnt != 2'd2);
  assign head = mem[rd_ptr];

  assign filt.valid      = (cnt != 2'd0);
  assign filt.out_byte   = head.out_byte;
  assign filt.byte_valid = head.byte_valid;
  assign filt.out_last   = head.out_last;

  // Track occupancy
  always_comb begin
    cnt_next = cnt;
    case ({push, pop})
      2'b10:   cnt_next = cnt + 2'd1;
      2'b01:   cnt_next = cnt - 2'd1;
      default: cnt_next = cnt;
    endcase
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      cnt <= cnt_next;
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
    end
  end

  // Store words
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

// File: rtl/vt100_escape_filter.sv
// Top level of the VT100 escape filter: window control, rule decode, output queue.
// Depends on vtf_pkg, vtf_in_if, vtf_out_if and the vtf_* submodules.
//
//   channel | dir | fields                          | meaning
//   raw     | in  | in_byte, buffer_end             | console byte, last byte of buffer
//   filt    | out | out_byte, byte_valid, out_last  | filtered word, byte flag, buffer end
//
// One byte per cycle in steady state; one head action per cycle on the 14-byte window.
// A translated clear-line sequence emits two words, holding input off while the second goes out.
// A buffer end drains the window: input is held off until the window is empty and the
// flush closes with its end-marked word.
// Output stalls fill a two-word queue; input stops once both it and the window are full.
// Reset clears fill, skip, flush and queue state; window bytes are not cleared.
module vt100_escape_filter import vtf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  vtf_in_if.sink    raw,
  vtf_out_if.source filt
);

  window_t           win;
  logic [FILL_W-1:0] fill;
  head_act_t         act;
  logic              room;
  logic              push;
  result_t           push_data;

  vtf_head_decode u_decode (
    .win  (win),
    .fill (fill),
    .act  (act)
  );

  vtf_window u_window (
    .clk       (clk),
    .rst       (rst),
    .raw       (raw),
    .act       (act),
    .room      (room),
    .win       (win),
    .fill      (fill),
    .push      (push),
    .push_data (push_data)
  );

  vtf_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .room      (room),
    .filt      (filt)
  );

endmodule

// File: rtl/vtf_checker.sv
// Port-level checks of the escape filter, bound to the top level.
// Depends on vt100_escape_filter_defines.svh.
`include "vt100_escape_filter_defines.svh"

module vtf_checker (
  input logic       clk,
  input logic       rst,
  input logic       raw_valid,
  input logic       raw_ready,
  input logic       raw_buffer_end,
  input logic       filt_valid,
  input logic       filt_ready,
  input logic [7:0] filt_out_byte,
  input logic       filt_byte_valid,
  input logic       filt_out_last
);

  // Hold input off while a buffer drains
  `VTF_ASSERT_NEXT(a_flush_blocks, raw_valid && raw_ready && raw_buffer_end, !raw_ready, "input accepted right after a buffer end")

  // Start with an empty queue after reset
  `VTF_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !filt_valid, "output valid right after reset")

  // Keep a stalled word in place
  `VTF_ASSERT_NEXT(a_stall_hold, filt_valid && !filt_ready, filt_valid && $stable(filt_out_byte) && $stable(filt_byte_valid) && $stable(filt_out_last), "stalled output word changed")

  // An empty marker only closes a buffer
  `VTF_ASSERT_NEXT(a_marker_last, filt_valid && filt_ready && !filt_byte_valid, $past(filt_out_last) && ($past(filt_out_byte) == 8'd0), "empty marker without end mark or with data")

endmodule

bind vt100_escape_filter vtf_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .raw_valid       (raw.valid),
  .raw_ready       (raw.ready),
  .raw_buffer_end  (raw.buffer_end),
  .filt_valid      (filt.valid),
  .filt_ready      (filt.ready),
  .filt_out_byte   (filt.out_byte),
  .filt_byte_valid (filt.byte_valid),
  .filt_out_last   (filt.out_last)
);
